// ----- rtl/bdec_pkg.sv -----
// Shared types and constants for the button debounce event counter.
// No dependencies.
`timescale 1ns / 1ps

package bdec_pkg;

    localparam int BUTTONS_DEF = 4;
    localparam int WINDOW_DEF  = 6;

    localparam int MODE_W  = 2;
    localparam int PIN_W   = 4;
    localparam int IDX_W   = 2;
    localparam int COUNT_W = 7;

    typedef enum logic [MODE_W-1:0] {
        MODE_TICK  = 2'd0,
        MODE_QUERY = 2'd1,
        MODE_CLEAR = 2'd2
    } t_mode;

    typedef struct packed {
        logic tick;
        logic clear;
        logic consume;
        logic pin;
    } t_btn_ctrl;

endpackage

// ----- rtl/bdec_button.sv -----
// One button lane: sample history, held flag and pending event count.
// Depends on bdec_pkg.
`timescale 1ns / 1ps

module bdec_button #(
    parameter int WINDOW = bdec_pkg::WINDOW_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  bdec_pkg::t_btn_ctrl           i_ctrl,
    output logic [bdec_pkg::COUNT_W-1:0]  o_count
);
    import bdec_pkg::*;

    logic [WINDOW-1:0]  r_hist;
    logic [WINDOW-1:0]  n_hist;
    logic               r_held;
    logic               n_held;
    logic [COUNT_W-1:0] r_count;
    logic [COUNT_W-1:0] n_count;

    always_comb begin
        n_hist  = r_hist;
        n_held  = r_held;
        n_count = r_count;
        if (i_ctrl.tick) begin
            n_hist = {r_hist[WINDOW-2:0], i_ctrl.pin};
            if (r_held) begin
                if (n_hist == '0) begin
                    n_held  = 1'b0;
                    n_count = r_count + COUNT_W'(1);
                end
            end else if (n_hist == '1) begin
                n_held = 1'b1;
            end
        end else if (i_ctrl.clear) begin
            n_held  = 1'b0;
            n_count = '0;
        end else if (i_ctrl.consume && (r_count != '0)) begin
            n_count = r_count - COUNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist  <= '0;
            r_held  <= 1'b0;
            r_count <= '0;
        end else begin
            r_hist  <= n_hist;
            r_held  <= n_held;
            r_count <= n_count;
        end
    end

    assign o_count = r_count;

endmodule

// ----- rtl/bdec_out_fifo.sv -----
// Two-entry result queue that decouples the output handshake from intake.
// Depends on bdec_pkg.
`timescale 1ns / 1ps

module bdec_out_fifo (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    input  logic [bdec_pkg::COUNT_W-1:0]  i_data,
    output logic                          o_full,
    output logic [1:0]                    o_level,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [bdec_pkg::COUNT_W-1:0]  o_data
);
    import bdec_pkg::*;

    logic [COUNT_W-1:0] r_data [2];
    logic               r_wr_ptr;
    logic               r_rd_ptr;
    logic [1:0]         r_level;
    logic [1:0]         n_level;
    logic               w_push;
    logic               w_pop;

    assign o_valid = (r_level != 2'd0);
    assign o_full  = (r_level == 2'd2);
    assign w_push  = i_push && !o_full;
    assign w_pop   = o_valid && i_ready;

    always_comb begin
        n_level = r_level;
        case ({w_push, w_pop})
            2'b10:   n_level = r_level + 2'd1;
            2'b01:   n_level = r_level - 2'd1;
            default: n_level = r_level;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_level  <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_level <= n_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_data[r_wr_ptr] <= i_data;
        end
    end

    assign o_data  = r_data[r_rd_ptr];
    assign o_level = r_level;

endmodule

// ----- rtl/button_debounce_event_counter.sv -----
// Top level of the button debounce event counter: button lanes and result queue.
// Depends on bdec_pkg, bdec_button and bdec_out_fifo.
`timescale 1ns / 1ps

// Takes one beat per clock while i_ready is high: a tick shifts every button's
// pin level into its history and updates held flags and event counts, a query
// returns the chosen button's count and decrements it if nonzero, a clear zeroes
// counts and held flags. Every beat finishes in the cycle it is accepted; a
// query's count is registered in a two-entry result queue and offered from there.
// i_ready drops only while both queue entries wait on the output side.
module button_debounce_event_counter #(
    parameter int BUTTONS = bdec_pkg::BUTTONS_DEF,
    parameter int WINDOW  = bdec_pkg::WINDOW_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          i_ready,
    input  logic [bdec_pkg::MODE_W-1:0]   i_mode,
    input  logic [bdec_pkg::PIN_W-1:0]    i_pin_levels,
    input  logic [bdec_pkg::IDX_W-1:0]    i_button_index,
    output logic                          o_valid,
    input  logic                          o_ready,
    output logic [bdec_pkg::COUNT_W-1:0]  o_event_count
);
    import bdec_pkg::*;

    logic               w_accept;
    logic               w_tick;
    logic               w_query;
    logic               w_clear;
    logic               w_full;
    logic [1:0]         w_level;
    logic [BUTTONS-1:0] w_sel;
    logic [COUNT_W-1:0] w_count [BUTTONS];
    logic [COUNT_W-1:0] w_result;
    logic               w_any_count;
    t_btn_ctrl          w_ctrl  [BUTTONS];

    assign i_ready  = !w_full;
    assign w_accept = i_valid && i_ready;
    assign w_tick   = w_accept && (i_mode == MODE_TICK);
    assign w_query  = w_accept && (i_mode == MODE_QUERY);
    assign w_clear  = w_accept && (i_mode == MODE_CLEAR);

    for (genvar g = 0; g < BUTTONS; g++) begin : g_lane
        if (g < (1 << IDX_W)) begin : g_sel
            assign w_sel[g] = (i_button_index == IDX_W'(g));
        end else begin : g_nosel
            assign w_sel[g] = 1'b0;
        end

        if (g < PIN_W) begin : g_pin
            assign w_ctrl[g].pin = i_pin_levels[g];
        end else begin : g_nopin
            assign w_ctrl[g].pin = 1'b0;
        end

        assign w_ctrl[g].tick    = w_tick;
        assign w_ctrl[g].clear   = w_clear;
        assign w_ctrl[g].consume = w_query && w_sel[g];

        bdec_button #(
            .WINDOW (WINDOW)
        ) u_button (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (w_ctrl[g]),
            .o_count (w_count[g])
        );
    end

    always_comb begin
        w_result    = '0;
        w_any_count = 1'b0;
        for (int i = 0; i < BUTTONS; i++) begin
            w_result    = w_result | (w_count[i] & {COUNT_W{w_sel[i]}});
            w_any_count = w_any_count | (w_count[i] != '0);
        end
    end

    bdec_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_query),
        .i_data  (w_result),
        .o_full  (w_full),
        .o_level (w_level),
        .o_valid (o_valid),
        .i_ready (o_ready),
        .o_data  (o_event_count)
    );

    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_level != 2'd3)
        else $error("result queue level out of range");

    a_query_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_query && !o_valid) |=> o_valid)
        else $error("query beat did not reach the output");

    a_clear_zeroes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_clear |=> !w_any_count)
        else $error("clear left a nonzero count");

    a_idle_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_valid && !w_query) |=> !o_valid)
        else $error("result appeared without a query");

endmodule
